FILE: design/rbcp_pkg.sv
// Shared types, widths and the quarter-wave sine table for the rotated box
// collide-and-push block. No dependencies.
package rbcp_pkg;

   // Field widths
   localparam int POS_W   = 32;
   localparam int SCALE_W = 31;
   localparam int ANGLE_W = 16;

   // Fixed point and table configuration
   localparam int SINE_TABLE_BITS = 8;
   localparam int FRAC_BITS       = 16;
   localparam int SINE_N          = 1 << SINE_TABLE_BITS;
   localparam int LUT_IDX_W       = SINE_TABLE_BITS + 1;
   localparam int TRIG_W          = FRAC_BITS + 1;
   localparam int QUAD_LSB        = ANGLE_W - 2;
   localparam int PROD_W          = SCALE_W + TRIG_W;

   // Datapath widths past the extents
   localparam int DIFF_W = POS_W + 1;
   localparam int PEN_W  = POS_W + 2;
   localparam int AMT_W  = POS_W + 2;
   localparam int SUM_W  = POS_W + 4;

   // Polynomial coefficients, Q30
   localparam longint unsigned POLY_A = 64'd1686629713;
   localparam longint unsigned POLY_B = 64'd688904866;
   localparam longint unsigned POLY_C = 64'd76016977;

   typedef logic [TRIG_W-1:0] lut_type [0:SINE_N];

   // Pipeline stage load enables
   typedef struct packed {
      logic s0;
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } adv_type;

   // Odd polynomial sine on [0,1] of a quarter turn, rounded to FRAC_BITS
   function automatic logic [TRIG_W-1:0] quarter_sine(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned r;
      x  = longint'(k) << (30 - SINE_TABLE_BITS);
      x2 = (x * x) >> 30;
      t  = (POLY_C * x2) >> 30;
      t  = POLY_B - t;
      t  = (t * x2) >> 30;
      t  = POLY_A - t;
      t  = (t * x) >> 30;
      r  = (t + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return r[TRIG_W-1:0];
   endfunction

   function automatic lut_type build_lut();
      lut_type lut;
      for (int k = 0; k <= SINE_N; k++) begin
         lut[k] = quarter_sine(k);
      end
      return lut;
   endfunction

   localparam lut_type SINE_LUT = build_lut();

endpackage

FILE: design/rbcp_extent.sv
// Axis-aligned half extents of one rotated box: table lookup and four
// products in one stage, sum and halve in the next. Uses rbcp_pkg.
module rbcp_extent (
   input  logic                            clock,
   input  rbcp_pkg::adv_type               adv,
   input  logic [rbcp_pkg::SCALE_W-1:0]    scale_w,
   input  logic [rbcp_pkg::SCALE_W-1:0]    scale_h,
   input  logic [rbcp_pkg::ANGLE_W-1:0]    angle,
   output logic [rbcp_pkg::SCALE_W-1:0]    half_w,
   output logic [rbcp_pkg::SCALE_W-1:0]    half_h
);
   import rbcp_pkg::*;

   logic [LUT_IDX_W-1:0] k_idx;
   logic [LUT_IDX_W-1:0] nk_idx;
   logic [TRIG_W-1:0]    lut_s;
   logic [TRIG_W-1:0]    lut_c;
   logic [TRIG_W-1:0]    sin_v;
   logic [TRIG_W-1:0]    cos_v;
   logic [PROD_W-1:0]    p_wc, p_hs, p_ws, p_hc;
   logic [SCALE_W-1:0]   wc_ff, hs_ff, ws_ff, hc_ff;
   logic [SCALE_W:0]     sum_w, sum_h;
   logic [SCALE_W-1:0]   half_w_ff, half_h_ff;

   // Quarter-wave lookup; odd quadrants swap sine and cosine
   always_comb begin
      k_idx  = {1'b0, angle[QUAD_LSB-1 -: SINE_TABLE_BITS]};
      nk_idx = LUT_IDX_W'(SINE_N) - k_idx;
      lut_s  = SINE_LUT[k_idx];
      lut_c  = SINE_LUT[nk_idx];
      if (angle[QUAD_LSB]) begin
         sin_v = lut_c;
         cos_v = lut_s;
      end else begin
         sin_v = lut_s;
         cos_v = lut_c;
      end
   end

   assign p_wc = PROD_W'(scale_w) * PROD_W'(cos_v);
   assign p_hs = PROD_W'(scale_h) * PROD_W'(sin_v);
   assign p_ws = PROD_W'(scale_w) * PROD_W'(sin_v);
   assign p_hc = PROD_W'(scale_h) * PROD_W'(cos_v);

   // Stage 1: truncated products
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         wc_ff <= p_wc[FRAC_BITS +: SCALE_W];
         hs_ff <= p_hs[FRAC_BITS +: SCALE_W];
         ws_ff <= p_ws[FRAC_BITS +: SCALE_W];
         hc_ff <= p_hc[FRAC_BITS +: SCALE_W];
      end
   end

   assign sum_w = {1'b0, wc_ff} + {1'b0, hs_ff};
   assign sum_h = {1'b0, ws_ff} + {1'b0, hc_ff};

   // Stage 2: half extents, truncating
   always_ff @(posedge clock) begin
      if (adv.s2) begin
         half_w_ff <= sum_w[SCALE_W:1];
         half_h_ff <= sum_h[SCALE_W:1];
      end
   end

   assign half_w = half_w_ff;
   assign half_h = half_h_ff;

endmodule

FILE: design/rbcp_resolve.sv
// Penetration, overlap test and saturated push of box A: pipeline stages
// three to five, ending in the result register. Uses rbcp_pkg.
module rbcp_resolve (
   input  logic                           clock,
   input  rbcp_pkg::adv_type              adv,
   input  logic [rbcp_pkg::SCALE_W-1:0]   hwa,
   input  logic [rbcp_pkg::SCALE_W-1:0]   hha,
   input  logic [rbcp_pkg::SCALE_W-1:0]   hwb,
   input  logic [rbcp_pkg::SCALE_W-1:0]   hhb,
   input  logic [rbcp_pkg::DIFF_W-1:0]    abs_dx,
   input  logic [rbcp_pkg::DIFF_W-1:0]    abs_dy,
   input  logic                           dx_pos,
   input  logic                           dy_pos,
   input  logic signed [rbcp_pkg::POS_W-1:0] ax,
   input  logic signed [rbcp_pkg::POS_W-1:0] ay,
   input  logic [rbcp_pkg::SCALE_W-1:0]   margin,
   output logic                           overlapping,
   output logic                           push_applied,
   output logic signed [rbcp_pkg::POS_W-1:0] pushed_x,
   output logic signed [rbcp_pkg::POS_W-1:0] pushed_y
);
   import rbcp_pkg::*;

   // Stage 3 signals
   logic [SCALE_W:0]         sum_x, sum_y;
   logic signed [PEN_W-1:0]  pen_x, pen_y;
   logic signed [PEN_W-1:0]  pen_x_ff, pen_y_ff;
   logic                     dx_pos3_ff, dy_pos3_ff;
   logic signed [POS_W-1:0]  ax3_ff, ay3_ff;

   // Stage 4 signals
   logic                     px_pos, py_pos;
   logic [AMT_W-1:0]         amt_x, amt_y;
   logic                     sel_y;
   logic [AMT_W-1:0]         amt4_ff;
   logic                     dir4_ff, sel_y4_ff, push4_ff, over4_ff;
   logic signed [POS_W-1:0]  ax4_ff, ay4_ff;

   // Stage 5 signals
   logic signed [SUM_W-1:0]  base_v, moved_v;
   logic signed [POS_W-1:0]  sat_v;
   logic                     sat_ovf;
   logic                     over_ff, push_ff;
   logic signed [POS_W-1:0]  pushed_x_ff, pushed_y_ff;

   // Stage 3: combined half extents minus center offset
   assign sum_x = {1'b0, hwa} + {1'b0, hwb};
   assign sum_y = {1'b0, hha} + {1'b0, hhb};
   assign pen_x = $signed(PEN_W'(sum_x)) - $signed(PEN_W'(abs_dx));
   assign pen_y = $signed(PEN_W'(sum_y)) - $signed(PEN_W'(abs_dy));

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         pen_x_ff   <= pen_x;
         pen_y_ff   <= pen_y;
         dx_pos3_ff <= dx_pos;
         dy_pos3_ff <= dy_pos;
         ax3_ff     <= ax;
         ay3_ff     <= ay;
      end
   end

   // Stage 4: axis choice and push distance with margin
   assign px_pos = !pen_x_ff[PEN_W-1] && (pen_x_ff != '0);
   assign py_pos = !pen_y_ff[PEN_W-1] && (pen_y_ff != '0);
   assign amt_x  = AMT_W'(pen_x_ff[DIFF_W-1:0]) + AMT_W'(margin);
   assign amt_y  = AMT_W'(pen_y_ff[DIFF_W-1:0]) + AMT_W'(margin);
   assign sel_y  = !(pen_x_ff < pen_y_ff);   // ties go along y

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         amt4_ff   <= sel_y ? amt_y : amt_x;
         dir4_ff   <= sel_y ? dy_pos3_ff : dx_pos3_ff;
         sel_y4_ff <= sel_y;
         push4_ff  <= px_pos && py_pos;
         over4_ff  <= !pen_x_ff[PEN_W-1] && !pen_y_ff[PEN_W-1];
         ax4_ff    <= ax3_ff;
         ay4_ff    <= ay3_ff;
      end
   end

   // Stage 5: move along the chosen axis, zero offset moves negative
   always_comb begin
      base_v  = sel_y4_ff ? SUM_W'(ay4_ff) : SUM_W'(ax4_ff);
      moved_v = dir4_ff ? base_v + $signed(SUM_W'(amt4_ff))
                        : base_v - $signed(SUM_W'(amt4_ff));
      sat_ovf = (moved_v[SUM_W-1:POS_W-1] != '0) && (moved_v[SUM_W-1:POS_W-1] != '1);
      if (!sat_ovf) begin
         sat_v = moved_v[POS_W-1:0];
      end else if (moved_v[SUM_W-1]) begin
         sat_v = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         sat_v = {1'b0, {(POS_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s5) begin
         over_ff     <= over4_ff;
         push_ff     <= push4_ff;
         pushed_x_ff <= (push4_ff && !sel_y4_ff) ? sat_v : ax4_ff;
         pushed_y_ff <= (push4_ff && sel_y4_ff) ? sat_v : ay4_ff;
      end
   end

   assign overlapping  = over_ff;
   assign push_applied = push_ff;
   assign pushed_x     = pushed_x_ff;
   assign pushed_y     = pushed_y_ff;

endmodule

FILE: design/rotated_box_collide_push.sv
// Top level of the rotated box collide-and-push block: input register,
// pipeline control, center offsets. Uses rbcp_pkg, rbcp_extent, rbcp_resolve.
//
// Usage:
//   req_*  : one word per box pair (A and B center, size, angle); taken when
//            req_valid and req_ready are both high.
//   rsp_*  : one word per request, in order: overlap flag, push flag and the
//            resolved center of A; taken when rsp_valid and rsp_ready are high.
//   csr_*  : writes push_margin; always ready. Write only while idle.
// Pipeline: from request accept to rsp_valid the word passes six
//   registers (input register, two extent stages, penetration, push distance,
//   result register).
// Throughput: one pair per cycle unless the output stalls; the six-stage
//   pipeline keeps each stage to one short step, the products in stage one.
// Stall: each stage holds while the one after it is full and stalled, so
//   bubbles are squeezed out; req_ready drops only when all six stages hold
//   words and rsp_ready is low.
// Reset: synchronous; empties the pipeline and clears push_margin to zero.
module rotated_box_collide_push (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rbcp_pkg::POS_W-1:0] req_a_pos_x,
   input  logic signed [rbcp_pkg::POS_W-1:0] req_a_pos_y,
   input  logic [rbcp_pkg::SCALE_W-1:0]      req_a_scale_x,
   input  logic [rbcp_pkg::SCALE_W-1:0]      req_a_scale_y,
   input  logic [rbcp_pkg::ANGLE_W-1:0]      req_a_angle,
   input  logic signed [rbcp_pkg::POS_W-1:0] req_b_pos_x,
   input  logic signed [rbcp_pkg::POS_W-1:0] req_b_pos_y,
   input  logic [rbcp_pkg::SCALE_W-1:0]      req_b_scale_x,
   input  logic [rbcp_pkg::SCALE_W-1:0]      req_b_scale_y,
   input  logic [rbcp_pkg::ANGLE_W-1:0]      req_b_angle,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_overlapping,
   output logic                              rsp_push_applied,
   output logic signed [rbcp_pkg::POS_W-1:0] rsp_pushed_x,
   output logic signed [rbcp_pkg::POS_W-1:0] rsp_pushed_y,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rbcp_pkg::SCALE_W-1:0]      csr_push_margin
);
   import rbcp_pkg::*;

   localparam int NUM_STAGES = 6;

   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   valid_in;
   logic [NUM_STAGES-1:0]   rdy;
   adv_type                 adv;

   logic [SCALE_W-1:0]      margin_ff;

   // Stage 0: input register
   logic signed [POS_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [SCALE_W-1:0]      asx_ff, asy_ff, bsx_ff, bsy_ff;
   logic [ANGLE_W-1:0]      aang_ff, bang_ff;

   // Stage 1: center offsets
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [POS_W-1:0]  ax1_ff, ay1_ff;

   // Stage 2: offset magnitudes and signs
   logic [DIFF_W-1:0]        abs_dx_ff, abs_dy_ff;
   logic                     dx_pos_ff, dy_pos_ff;
   logic signed [POS_W-1:0]  ax2_ff, ay2_ff;

   logic [SCALE_W-1:0]       hwa, hha, hwb, hhb;

   // Ready ripples back from the response register
   always_comb begin
      rdy[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
   end

   assign adv = '{s0: rdy[0], s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Margin register
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else if (csr_valid) begin
         margin_ff <= csr_push_margin;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s0) begin
         ax_ff   <= req_a_pos_x;
         ay_ff   <= req_a_pos_y;
         bx_ff   <= req_b_pos_x;
         by_ff   <= req_b_pos_y;
         asx_ff  <= req_a_scale_x;
         asy_ff  <= req_a_scale_y;
         bsx_ff  <= req_b_scale_x;
         bsy_ff  <= req_b_scale_y;
         aang_ff <= req_a_angle;
         bang_ff <= req_b_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         dx_ff  <= DIFF_W'(ax_ff) - DIFF_W'(bx_ff);
         dy_ff  <= DIFF_W'(ay_ff) - DIFF_W'(by_ff);
         ax1_ff <= ax_ff;
         ay1_ff <= ay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         abs_dx_ff <= dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
         abs_dy_ff <= dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
         dx_pos_ff <= !dx_ff[DIFF_W-1] && (dx_ff != '0);
         dy_pos_ff <= !dy_ff[DIFF_W-1] && (dy_ff != '0);
         ax2_ff    <= ax1_ff;
         ay2_ff    <= ay1_ff;
      end
   end

   // Box extents
   rbcp_extent u_extent_a (
      .clock   (clock),
      .adv     (adv),
      .scale_w (asx_ff),
      .scale_h (asy_ff),
      .angle   (aang_ff),
      .half_w  (hwa),
      .half_h  (hha)
   );

   rbcp_extent u_extent_b (
      .clock   (clock),
      .adv     (adv),
      .scale_w (bsx_ff),
      .scale_h (bsy_ff),
      .angle   (bang_ff),
      .half_w  (hwb),
      .half_h  (hhb)
   );

   // Penetration and push
   rbcp_resolve u_resolve (
      .clock        (clock),
      .adv          (adv),
      .hwa          (hwa),
      .hha          (hha),
      .hwb          (hwb),
      .hhb          (hhb),
      .abs_dx       (abs_dx_ff),
      .abs_dy       (abs_dy_ff),
      .dx_pos       (dx_pos_ff),
      .dy_pos       (dy_pos_ff),
      .ax           (ax2_ff),
      .ay           (ay2_ff),
      .margin       (margin_ff),
      .overlapping  (rsp_overlapping),
      .push_applied (rsp_push_applied),
      .pushed_x     (rsp_pushed_x),
      .pushed_y     (rsp_pushed_y)
   );

   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign csr_ready = 1'b1;

endmodule

FILE: design/rbcp_checker.sv
// Port-level checks for rotated_box_collide_push, bound to the top level.
// Depends on rbcp_pkg and the top level's ports.
module rbcp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_overlapping,
   input logic                              rsp_push_applied,
   input logic signed [rbcp_pkg::POS_W-1:0] rsp_pushed_x,
   input logic signed [rbcp_pkg::POS_W-1:0] rsp_pushed_y,
   input logic                              csr_ready
);
   import rbcp_pkg::*;

   // Pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pushed_x)
         && $stable(rsp_pushed_y) && $stable(rsp_push_applied))
      else $error("stalled response changed");

   // A push only happens on overlapping boxes
   a_push_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_applied |-> rsp_overlapping)
      else $error("push without overlap");

   // Input is never blocked unless the output is stalled
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> (req_ready && csr_ready))
      else $error("input stalled while output free");

endmodule

bind rotated_box_collide_push rbcp_checker u_rbcp_checker (.*);
